>>> design/http_request_byte_parser_assert.svh
// Assertion helpers for the request byte parser checker.
`ifndef HTTP_REQUEST_BYTE_PARSER_ASSERT_SVH
`define HTTP_REQUEST_BYTE_PARSER_ASSERT_SVH

// Clocked assertion, quiet while reset is applied.
`define HRBP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Assertion on a result beat that is being shown.
`define HRBP_ASSERT_BEAT(label, cond, msg) \
	`HRBP_ASSERT(label, out_valid |-> (cond), msg)

`endif

>>> design/hrbp_pkg.sv
package hrbp_pkg;

	typedef enum logic [3:0] {
		PH_START   = 4'd0,
		PH_GET     = 4'd1,
		PH_POST    = 4'd2,
		PH_SP1     = 4'd3,
		PH_PATH    = 4'd4,
		PH_SP2     = 4'd5,
		PH_PROTO   = 4'd6,
		PH_SLASH   = 4'd7,
		PH_VERSION = 4'd8,
		PH_LF      = 4'd9,
		PH_LINE    = 4'd10,
		PH_KEY     = 4'd11,
		PH_VSKIP   = 4'd12,
		PH_VALUE   = 4'd13,
		PH_BSKIP   = 4'd14,
		PH_BODY    = 4'd15
	} phase_t;

	typedef enum logic [3:0] {
		CLS_METHOD  = 4'd0,
		CLS_SPACE   = 4'd1,
		CLS_PATH    = 4'd2,
		CLS_PROTO   = 4'd3,
		CLS_SLASH   = 4'd4,
		CLS_VERSION = 4'd5,
		CLS_BREAK   = 4'd6,
		CLS_KEY     = 4'd7,
		CLS_COLON   = 4'd8,
		CLS_VALUE   = 4'd9,
		CLS_BODY    = 4'd10,
		CLS_REJECT  = 4'd11,
		CLS_NONE    = 4'd15
	} class_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_METH = 2'd1,
		ST_NO_PROTO = 2'd2,
		ST_NO_SLASH = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		METH_NONE = 2'd0,
		METH_GET  = 2'd1,
		METH_POST = 2'd2
	} method_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_P     = 8'h50;

	localparam logic [2:0] GET_LEN  = 3'd3;
	localparam logic [2:0] POST_LEN = 3'd4;
	localparam logic [2:0] HTTP_LEN = 3'd4;
	localparam logic [7:0] HDR_MAX  = 8'd255;

	// Parser state carried from one byte to the next.
	typedef struct packed {
		phase_t     phase;
		logic [2:0] match_pos;
		method_t    method;
		status_t    err;
		logic [7:0] hdr_cnt;
		class_t     last_class;
	} pstate_t;

	localparam pstate_t PSTATE_RESET = '{
		phase:      PH_START,
		match_pos:  3'd0,
		method:     METH_NONE,
		err:        ST_OK,
		hdr_cnt:    8'd0,
		last_class: CLS_NONE
	};

	// Tag fields of one result beat, next to the echoed byte.
	typedef struct packed {
		class_t     byte_class;
		logic       field_start;
		logic [7:0] header_index;
		method_t    method_code;
		status_t    status;
	} tag_t;

	function automatic logic is_ws(input logic [7:0] b);
		return b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
	endfunction

	function automatic logic is_nl(input logic [7:0] b);
		return b inside {CH_CR, CH_LF};
	endfunction

	// Expected method letter; pos is below the word length.
	function automatic logic [7:0] method_char(input logic get, input logic [1:0] pos);
		logic [7:0] c;
		if (get) begin
			case (pos)
				2'd0:    c = "G";
				2'd1:    c = "E";
				default: c = "T";
			endcase
		end else begin
			case (pos)
				2'd0:    c = "P";
				2'd1:    c = "O";
				2'd2:    c = "S";
				default: c = "T";
			endcase
		end
		return c;
	endfunction

	function automatic logic [7:0] http_char(input logic [1:0] pos);
		logic [7:0] c;
		case (pos)
			2'd0:    c = "H";
			2'd3:    c = "P";
			default: c = "T";
		endcase
		return c;
	endfunction

endpackage

>>> design/hrbp_in_if.sv
interface hrbp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

>>> design/hrbp_out_if.sv
interface hrbp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] echo_byte;
	logic [3:0] byte_class;
	logic       field_start;
	logic [7:0] header_index;
	logic [1:0] method_code;
	logic       done_res;
	logic [1:0] status;

	modport source (output valid, output echo_byte, output byte_class, output field_start,
		output header_index, output method_code, output done_res, output status,
		input ready);
	modport sink (input valid, input echo_byte, input byte_class, input field_start,
		input header_index, input method_code, input done_res, input status,
		output ready);
endinterface

>>> design/hrbp_step.sv
// Next-state and tag logic for one byte.
module hrbp_step (
	input  hrbp_pkg::pstate_t st,
	input  logic [7:0]        data_byte,
	input  logic              last,
	output hrbp_pkg::pstate_t nxt,
	output hrbp_pkg::tag_t    tag
);

	hrbp_pkg::phase_t ph;
	hrbp_pkg::class_t cls;
	logic             ws;
	logic             nl;
	logic             is_get;
	logic [2:0]       wlen;
	logic [2:0]       mp_inc;

	always_comb begin
		nxt    = st;
		cls    = hrbp_pkg::CLS_REJECT;
		ph     = st.phase;
		ws     = hrbp_pkg::is_ws(data_byte);
		nl     = hrbp_pkg::is_nl(data_byte);
		is_get = (st.phase == hrbp_pkg::PH_GET);
		wlen   = is_get ? hrbp_pkg::GET_LEN : hrbp_pkg::POST_LEN;
		mp_inc = st.match_pos + 3'd1;

		if (st.err == hrbp_pkg::ST_OK) begin
			// Fall through phases that hand the byte on to the next one.
			if (ph == hrbp_pkg::PH_SP2 && !ws) begin
				ph            = hrbp_pkg::PH_PROTO;
				nxt.match_pos = 3'd0;
			end
			if (ph == hrbp_pkg::PH_LF && data_byte != hrbp_pkg::CH_LF)
				ph = hrbp_pkg::PH_LINE;
			if (ph == hrbp_pkg::PH_LINE && (data_byte == hrbp_pkg::CH_NUL || nl))
				ph = hrbp_pkg::PH_BSKIP;
			nxt.phase = ph;
			mp_inc    = nxt.match_pos + 3'd1;

			case (ph)
				hrbp_pkg::PH_START: begin
					if (data_byte == hrbp_pkg::CH_G) begin
						nxt.phase     = hrbp_pkg::PH_GET;
						nxt.match_pos = 3'd1;
						cls           = hrbp_pkg::CLS_METHOD;
					end else if (data_byte == hrbp_pkg::CH_P) begin
						nxt.phase     = hrbp_pkg::PH_POST;
						nxt.match_pos = 3'd1;
						cls           = hrbp_pkg::CLS_METHOD;
					end else begin
						nxt.err    = hrbp_pkg::ST_BAD_METH;
						nxt.method = hrbp_pkg::METH_NONE;
					end
				end
				hrbp_pkg::PH_GET, hrbp_pkg::PH_POST: begin
					if (st.match_pos < wlen && data_byte ==
							hrbp_pkg::method_char(is_get, st.match_pos[1:0])) begin
						cls           = hrbp_pkg::CLS_METHOD;
						nxt.match_pos = mp_inc;
						if (mp_inc == wlen) begin
							nxt.method    = is_get ? hrbp_pkg::METH_GET : hrbp_pkg::METH_POST;
							nxt.phase     = hrbp_pkg::PH_SP1;
							nxt.match_pos = 3'd0;
						end
					end else begin
						nxt.err    = hrbp_pkg::ST_BAD_METH;
						nxt.method = hrbp_pkg::METH_NONE;
					end
				end
				hrbp_pkg::PH_SP1: begin
					if (ws)
						cls = hrbp_pkg::CLS_SPACE;
					else begin
						nxt.phase = hrbp_pkg::PH_PATH;
						cls       = hrbp_pkg::CLS_PATH;
					end
				end
				hrbp_pkg::PH_PATH: begin
					if (data_byte == hrbp_pkg::CH_SPACE) begin
						nxt.phase = hrbp_pkg::PH_SP2;
						cls       = hrbp_pkg::CLS_SPACE;
					end else
						cls = hrbp_pkg::CLS_PATH;
				end
				hrbp_pkg::PH_SP2: begin
					cls = hrbp_pkg::CLS_SPACE;
				end
				hrbp_pkg::PH_PROTO: begin
					if (data_byte == hrbp_pkg::http_char(nxt.match_pos[1:0])) begin
						cls           = hrbp_pkg::CLS_PROTO;
						nxt.match_pos = mp_inc;
						if (mp_inc >= hrbp_pkg::HTTP_LEN) begin
							nxt.phase     = hrbp_pkg::PH_SLASH;
							nxt.match_pos = 3'd0;
						end
					end else begin
						nxt.err    = hrbp_pkg::ST_NO_PROTO;
						nxt.method = hrbp_pkg::METH_NONE;
					end
				end
				hrbp_pkg::PH_SLASH: begin
					if (data_byte == hrbp_pkg::CH_SLASH) begin
						nxt.phase = hrbp_pkg::PH_VERSION;
						cls       = hrbp_pkg::CLS_SLASH;
					end else begin
						nxt.err    = hrbp_pkg::ST_NO_SLASH;
						nxt.method = hrbp_pkg::METH_NONE;
					end
				end
				hrbp_pkg::PH_VERSION, hrbp_pkg::PH_VALUE: begin
					if (nl) begin
						nxt.phase = (data_byte == hrbp_pkg::CH_CR) ?
							hrbp_pkg::PH_LF : hrbp_pkg::PH_LINE;
						cls = hrbp_pkg::CLS_BREAK;
					end else
						cls = (ph == hrbp_pkg::PH_VERSION) ?
							hrbp_pkg::CLS_VERSION : hrbp_pkg::CLS_VALUE;
				end
				hrbp_pkg::PH_LF: begin
					nxt.phase = hrbp_pkg::PH_LINE;
					cls       = hrbp_pkg::CLS_BREAK;
				end
				hrbp_pkg::PH_LINE: begin
					if (st.hdr_cnt != hrbp_pkg::HDR_MAX)
						nxt.hdr_cnt = st.hdr_cnt + 8'd1;
					if (data_byte == hrbp_pkg::CH_COLON) begin
						nxt.phase = hrbp_pkg::PH_VSKIP;
						cls       = hrbp_pkg::CLS_COLON;
					end else begin
						nxt.phase = hrbp_pkg::PH_KEY;
						cls       = hrbp_pkg::CLS_KEY;
					end
				end
				hrbp_pkg::PH_KEY: begin
					if (data_byte == hrbp_pkg::CH_COLON) begin
						nxt.phase = hrbp_pkg::PH_VSKIP;
						cls       = hrbp_pkg::CLS_COLON;
					end else
						cls = hrbp_pkg::CLS_KEY;
				end
				hrbp_pkg::PH_VSKIP: begin
					if (ws)
						cls = hrbp_pkg::CLS_SPACE;
					else begin
						nxt.phase = hrbp_pkg::PH_VALUE;
						cls       = hrbp_pkg::CLS_VALUE;
					end
				end
				hrbp_pkg::PH_BSKIP: begin
					if (ws)
						cls = hrbp_pkg::CLS_SPACE;
					else begin
						nxt.phase = hrbp_pkg::PH_BODY;
						cls       = hrbp_pkg::CLS_BODY;
					end
				end
				default: begin
					cls = hrbp_pkg::CLS_BODY;
				end
			endcase
		end

		// Truncated before the slash: flag by how far the request line got.
		if (last && nxt.err == hrbp_pkg::ST_OK && nxt.phase < hrbp_pkg::PH_VERSION) begin
			if (nxt.phase <= hrbp_pkg::PH_POST)
				nxt.err = hrbp_pkg::ST_BAD_METH;
			else if (nxt.phase <= hrbp_pkg::PH_PROTO)
				nxt.err = hrbp_pkg::ST_NO_PROTO;
			else
				nxt.err = hrbp_pkg::ST_NO_SLASH;
			nxt.method = hrbp_pkg::METH_NONE;
		end

		tag.byte_class   = cls;
		tag.field_start  = (cls != st.last_class);
		tag.header_index = nxt.hdr_cnt;
		tag.method_code  = nxt.method;
		tag.status       = nxt.err;

		nxt.last_class = cls;
		if (last)
			nxt = hrbp_pkg::PSTATE_RESET;
	end

endmodule

>>> design/http_request_byte_parser.sv
// Channel | Dir | Payload                                                      | Beat
// --------+-----+--------------------------------------------------------------+------------
// req     | in  | data_byte[7:0], last                                         | one byte
// tag     | out | echo_byte, byte_class, field_start, header_index,           | one tag
//         |     | method_code, done_res, status                                |
//
// One byte per cycle sustained while tag is not stalled; a byte passes through the input register and then the
// result register on its way to tag. The byte-to-byte parser state closes a loop through hrbp_step and st_q.
// arst_n clears the stage valids and puts the parser at the start of a request.
// A stall on tag holds the result register; req keeps flowing into the input
// register until both stages are full, then req.ready drops.
module http_request_byte_parser (
	input  logic       clk,
	input  logic       arst_n,
	hrbp_in_if.sink    req,
	hrbp_out_if.source tag
);

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Result register.
	logic           valid_s2;
	logic [7:0]     byte_s2;
	logic           last_s2;
	hrbp_pkg::tag_t tag_s2;

	// Parser state.
	hrbp_pkg::pstate_t st_q;
	hrbp_pkg::pstate_t st_nxt;
	hrbp_pkg::tag_t    tag_nxt;

	logic advance;

	// Move a byte into the result register when that register is free or draining.
	assign advance   = valid_s1 && (!valid_s2 || tag.ready);
	assign req.ready = !valid_s1 || advance;

	hrbp_step u_step (
		.st        (st_q),
		.data_byte (byte_s1),
		.last      (last_s1),
		.nxt       (st_nxt),
		.tag       (tag_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Payload: load on every accepted beat.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			byte_s1 <= req.data_byte;
			last_s1 <= req.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			st_q     <= hrbp_pkg::PSTATE_RESET;
		end else begin
			if (advance) begin
				valid_s2 <= 1'b1;
				st_q     <= st_nxt;
			end else if (tag.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_s2 <= byte_s1;
			last_s2 <= last_s1;
			tag_s2  <= tag_nxt;
		end
	end

	assign tag.valid        = valid_s2;
	assign tag.echo_byte    = byte_s2;
	assign tag.byte_class   = tag_s2.byte_class;
	assign tag.field_start  = tag_s2.field_start;
	assign tag.header_index = tag_s2.header_index;
	assign tag.method_code  = tag_s2.method_code;
	assign tag.done_res     = last_s2;
	assign tag.status       = tag_s2.status;

endmodule

>>> design/hrbp_checker.sv
`include "http_request_byte_parser_assert.svh"

module hrbp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] echo_byte,
	input logic [3:0] byte_class,
	input logic       field_start,
	input logic [7:0] header_index,
	input logic [1:0] method_code,
	input logic       done_res,
	input logic [1:0] status
);

	`HRBP_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(echo_byte) && $stable(byte_class) && $stable(field_start) && $stable(header_index) && $stable(method_code) && $stable(done_res) && $stable(status), "tag beat changed while stalled")
	`HRBP_ASSERT_BEAT(a_meth_ok, method_code == hrbp_pkg::METH_NONE || status == hrbp_pkg::ST_OK, "method reported with an error")
	`HRBP_ASSERT_BEAT(a_rej_err, byte_class != hrbp_pkg::CLS_REJECT || status != hrbp_pkg::ST_OK, "rejected byte without an error")
	`HRBP_ASSERT_BEAT(a_hdr_idx, !(byte_class == hrbp_pkg::CLS_KEY || byte_class == hrbp_pkg::CLS_COLON || byte_class == hrbp_pkg::CLS_VALUE) || header_index != 8'd0, "header byte outside a header")

endmodule

bind http_request_byte_parser hrbp_checker u_hrbp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (tag.valid),
	.out_ready    (tag.ready),
	.echo_byte    (tag.echo_byte),
	.byte_class   (tag.byte_class),
	.field_start  (tag.field_start),
	.header_index (tag.header_index),
	.method_code  (tag.method_code),
	.done_res     (tag.done_res),
	.status       (tag.status)
);
